>>> rtl/drsa_pkg.sv
`timescale 1ns / 1ps
package drsa_pkg;

   // table size default and internal slot arithmetic width
   localparam int SLOTS_DEFAULT = 2048;
   localparam int EXT_W = 13;

   // free map word organization
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_SEL_W = 5;

   // port field widths
   localparam int FUNC_W = 2;
   localparam int INDEX_W = 11;
   localparam int TIME_W = 32;
   localparam int STATUS_W = 2;
   localparam int SERIAL_W = 16;
   localparam int COUNT_W = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FORCE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_REUSE = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REUSE_DELAY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EARLY_WINDOW = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTECTED = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELETE_EN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_WARN_EN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD = 3'd5;

   // configuration reset values
   localparam logic [15:0] RST_REUSE_DELAY = 16'd1000;
   localparam logic [15:0] RST_EARLY_WINDOW = 16'd2000;
   localparam logic [7:0] RST_PROTECTED = 8'd0;
   localparam logic RST_DELETE_EN = 1'b1;
   localparam logic RST_LOW_WARN_EN = 1'b0;
   localparam logic [COUNT_W-1:0] RST_LOW_THRESHOLD = 12'd8;

   // serial value of a slot that is handed out
   localparam logic [SERIAL_W-1:0] SERIAL_UNASSIGNED = 16'hFFFF;

   // controller to datapath commands
   typedef struct packed {
      logic req_load;
      logic ptr_clear;
      logic ptr_inc;
      logic map_rd_hw;
      logic idx_rd;
      logic bits_load;
      logic age_clear;
      logic drop_bit;
      logic scan_claim;
      logic reuse_done;
      logic fresh_full;
      logic fresh_commit;
      logic idx_bad;
      logic idx_commit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic idx_in_range;
      logic scan_end;
      logic bits_empty;
      logic eligible;
      logic table_full;
   } sts_type;

endpackage

>>> rtl/drsa_ram.sv
`timescale 1ns / 1ps
module drsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input logic clock,
   input logic wr_en,
   input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/drsa_ctrl.sv
`timescale 1ns / 1ps
module drsa_ctrl
   import drsa_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b0000000001,
      S_DECODE    = 10'b0000000010,
      S_IDX_EVAL  = 10'b0000000100,
      S_SCAN_RD   = 10'b0000001000,
      S_SCAN_LD   = 10'b0000010000,
      S_SCAN_PICK = 10'b0000100000,
      S_SCAN_EVAL = 10'b0001000000,
      S_FRESH     = 10'b0010000000,
      S_FRESH_WR  = 10'b0100000000,
      S_SPARE     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.func == FUNC_ALLOC || sts.func == FUNC_REUSE) begin
               cmd.ptr_clear = 1'b1;
               state_in = S_SCAN_RD;
            end else if (!sts.idx_in_range) begin
               cmd.idx_bad = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.idx_rd = 1'b1;
               state_in = S_IDX_EVAL;
            end
         end
         S_IDX_EVAL: begin
            cmd.idx_commit = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN_RD: begin
            if (!sts.scan_end) begin
               state_in = S_SCAN_LD;
            end else if (sts.func == FUNC_REUSE) begin
               cmd.reuse_done = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_FRESH;
            end
         end
         S_SCAN_LD: begin
            cmd.bits_load = 1'b1;
            state_in = S_SCAN_PICK;
         end
         S_SCAN_PICK: begin
            if (sts.bits_empty) begin
               cmd.ptr_inc = 1'b1;
               state_in = S_SCAN_RD;
            end else if (sts.func == FUNC_REUSE) begin
               cmd.age_clear = 1'b1;
            end else begin
               state_in = S_SCAN_EVAL;
            end
         end
         S_SCAN_EVAL: begin
            if (sts.eligible) begin
               cmd.scan_claim = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.drop_bit = 1'b1;
               state_in = S_SCAN_PICK;
            end
         end
         S_FRESH: begin
            if (sts.table_full) begin
               cmd.fresh_full = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.map_rd_hw = 1'b1;
               state_in = S_FRESH_WR;
            end
         end
         S_FRESH_WR: begin
            cmd.fresh_commit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> rtl/drsa_datapath.sv
`timescale 1ns / 1ps
module drsa_datapath
   import drsa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input cmd_type cmd,
   output sts_type sts,
   input logic [FUNC_W-1:0] req_func,
   input logic [INDEX_W-1:0] req_slot_index,
   input logic [TIME_W-1:0] req_now_ms,
   input logic csr_write_en,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata,
   output logic rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0] rsp_granted_slot,
   output logic [SERIAL_W-1:0] rsp_slot_serial,
   output logic rsp_explicit_delete,
   output logic rsp_low_space,
   output logic [COUNT_W-1:0] rsp_used_span,
   output logic [COUNT_W-1:0] rsp_free_total
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int WORDS = (SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WAW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WPW = $clog2(WORDS + 1);

   // configuration registers
   logic [15:0] delay_ff, early_ff;
   logic [7:0] prot_ff;
   logic del_en_ff, warn_en_ff;
   logic [COUNT_W-1:0] thr_ff;

   // request and allocator state
   logic [FUNC_W-1:0] func_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [TIME_W-1:0] now_ff;
   logic [CW-1:0] hw_ff, hw_in;
   logic [CW-1:0] fc_ff, fc_in;
   logic [WPW-1:0] ptr_ff, ptr_in;
   logic [MAP_WORD_BITS-1:0] bits_ff, bits_in;
   logic [MAP_WORD_BITS-1:0] word_ff, word_in;

   // result registers
   logic strobe_ff, strobe_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [INDEX_W-1:0] slot_ff, slot_in;
   logic [SERIAL_W-1:0] ser_ff, ser_in;
   logic del_ff, del_in;
   logic low_ff, low_in;

   // memory ports
   logic map_we;
   logic [WAW-1:0] map_waddr, map_raddr;
   logic [MAP_WORD_BITS-1:0] map_wdata, map_rdata;
   logic age_we;
   logic [IW-1:0] age_addr;
   logic [TIME_W-1:0] age_wdata, age_rdata;
   logic ser_we;
   logic [IW-1:0] ser_waddr;
   logic [SERIAL_W-1:0] ser_wdata, ser_rdata;

   // derived values
   logic [EXT_W-1:0] hw_ext, idx_ext, ptr_base, cand_ext, remain;
   logic [MAP_SEL_W-1:0] pick;
   logic [MAP_WORD_BITS-1:0] scan_mask;
   logic [TIME_W-1:0] age_diff;
   logic idx_bit, idx_prot;
   logic [CW-1:0] fc_dec;

   function automatic logic [MAP_SEL_W-1:0] lowest_bit(input logic [MAP_WORD_BITS-1:0] v);
      logic [MAP_SEL_W-1:0] r;
      r = '0;
      for (int k = MAP_WORD_BITS - 1; k >= 0; k--) begin
         if (v[k]) begin
            r = MAP_SEL_W'(k);
         end
      end
      return r;
   endfunction

   drsa_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(WORDS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   drsa_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_addr),
      .wr_data (age_wdata),
      .rd_addr (age_addr),
      .rd_data (age_rdata)
   );

   drsa_ram #(.WIDTH(SERIAL_W), .DEPTH(SLOTS)) u_ser_ram (
      .clock   (clock),
      .wr_en   (ser_we),
      .wr_addr (ser_waddr),
      .wr_data (ser_wdata),
      .rd_addr (idx_ext[IW-1:0]),
      .rd_data (ser_rdata)
   );

   // slot arithmetic in a common width
   assign hw_ext = EXT_W'(hw_ff);
   assign idx_ext = EXT_W'(idx_ff);
   assign ptr_base = EXT_W'(ptr_ff) << MAP_SEL_W;
   assign pick = lowest_bit(bits_ff);
   assign cand_ext = ptr_base | EXT_W'(pick);
   assign remain = EXT_W'(SLOTS) - hw_ext - EXT_W'(1);
   assign age_diff = now_ff - age_rdata;
   assign idx_bit = map_rdata[idx_ext[MAP_SEL_W-1:0]];
   assign idx_prot = (idx_ext >= EXT_W'(1)) && (idx_ext <= EXT_W'(prot_ff));
   assign fc_dec = (fc_ff != '0) ? fc_ff - CW'(1) : fc_ff;

   // the free time write of a free goes to the requested slot,
   // otherwise the address follows the scan candidate
   assign age_addr = cmd.idx_commit ? idx_ext[IW-1:0] : cand_ext[IW-1:0];

   // candidate bits of the loaded word: below high water, above player slots on reuse
   always_comb begin
      logic [EXT_W-1:0] g;
      g = '0;
      for (int k = 0; k < MAP_WORD_BITS; k++) begin
         g = ptr_base + EXT_W'(k);
         scan_mask[k] = (g < hw_ext) && (func_ff != FUNC_REUSE || g > EXT_W'(prot_ff));
      end
   end

   // status to the controller
   always_comb begin
      sts.func = func_ff;
      sts.idx_in_range = idx_ext < hw_ext;
      sts.scan_end = ptr_base >= hw_ext;
      sts.bits_empty = (bits_ff == '0);
      sts.eligible = (age_rdata < TIME_W'(early_ff)) ||
                     ((now_ff >= age_rdata) && (age_diff >= TIME_W'(delay_ff)));
      sts.table_full = hw_ext >= EXT_W'(SLOTS);
   end

   // free map read address
   always_comb begin
      if (cmd.map_rd_hw) begin
         map_raddr = hw_ext[MAP_SEL_W +: WAW];
      end else if (cmd.idx_rd) begin
         map_raddr = idx_ext[MAP_SEL_W +: WAW];
      end else begin
         map_raddr = ptr_ff[WAW-1:0];
      end
   end

   // memory writes and next state
   always_comb begin
      map_we = 1'b0;
      map_waddr = ptr_ff[WAW-1:0];
      map_wdata = word_ff;
      age_we = 1'b0;
      age_wdata = '0;
      ser_we = 1'b0;
      ser_waddr = idx_ext[IW-1:0];
      ser_wdata = SERIAL_UNASSIGNED;
      hw_in = hw_ff;
      fc_in = fc_ff;
      ptr_in = ptr_ff;
      bits_in = bits_ff;
      word_in = word_ff;
      strobe_in = 1'b0;
      st_in = st_ff;
      slot_in = slot_ff;
      ser_in = ser_ff;
      del_in = del_ff;
      low_in = low_ff;

      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end
      if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + WPW'(1);
      end
      if (cmd.bits_load) begin
         bits_in = map_rdata & scan_mask;
         word_in = map_rdata;
      end
      if (cmd.drop_bit) begin
         bits_in[pick] = 1'b0;
      end

      // immediate reuse: zero one free time a cycle
      if (cmd.age_clear) begin
         age_we = 1'b1;
         bits_in[pick] = 1'b0;
      end

      // reuse of the lowest eligible freed slot
      if (cmd.scan_claim) begin
         map_we = 1'b1;
         map_wdata[pick] = 1'b0;
         ser_we = 1'b1;
         ser_waddr = cand_ext[IW-1:0];
         fc_in = fc_dec;
         strobe_in = 1'b1;
         st_in = ST_OK;
         slot_in = INDEX_W'(cand_ext);
         ser_in = SERIAL_UNASSIGNED;
         del_in = (age_rdata == '0) && del_en_ff;
         low_in = 1'b0;
      end

      // extend the high-water mark
      if (cmd.fresh_commit) begin
         map_we = 1'b1;
         map_waddr = hw_ext[MAP_SEL_W +: WAW];
         map_wdata = map_rdata;
         map_wdata[hw_ext[MAP_SEL_W-1:0]] = 1'b0;
         ser_we = 1'b1;
         ser_waddr = hw_ext[IW-1:0];
         hw_in = hw_ff + CW'(1);
         strobe_in = 1'b1;
         st_in = ST_OK;
         slot_in = INDEX_W'(hw_ext);
         ser_in = SERIAL_UNASSIGNED;
         del_in = 1'b0;
         low_in = warn_en_ff && (remain <= EXT_W'(thr_ff));
      end

      if (cmd.fresh_full || cmd.reuse_done) begin
         strobe_in = 1'b1;
         st_in = cmd.fresh_full ? ST_EXHAUSTED : ST_OK;
         slot_in = '0;
         ser_in = '0;
         del_in = 1'b0;
         low_in = 1'b0;
      end

      if (cmd.idx_bad) begin
         strobe_in = 1'b1;
         st_in = ST_BAD_INDEX;
         slot_in = idx_ff;
         ser_in = '0;
         del_in = 1'b0;
         low_in = 1'b0;
      end

      // forced allocate or free of an in-range slot
      if (cmd.idx_commit) begin
         strobe_in = 1'b1;
         slot_in = idx_ff;
         ser_in = ser_rdata;
         del_in = 1'b0;
         low_in = 1'b0;
         map_waddr = idx_ext[MAP_SEL_W +: WAW];
         map_wdata = map_rdata;
         if (func_ff == FUNC_FORCE) begin
            if (!idx_bit) begin
               st_in = ST_BAD_INDEX;
            end else begin
               map_we = 1'b1;
               map_wdata[idx_ext[MAP_SEL_W-1:0]] = 1'b0;
               ser_we = 1'b1;
               fc_in = fc_dec;
               st_in = ST_OK;
               ser_in = SERIAL_UNASSIGNED;
            end
         end else begin
            if (idx_bit || idx_prot) begin
               st_in = ST_IGNORED;
            end else begin
               map_we = 1'b1;
               map_wdata[idx_ext[MAP_SEL_W-1:0]] = 1'b1;
               age_we = 1'b1;
               age_wdata = now_ff;
               ser_we = 1'b1;
               ser_wdata = ser_rdata + SERIAL_W'(1);
               fc_in = fc_ff + CW'(1);
               st_in = ST_OK;
               ser_in = ser_rdata + SERIAL_W'(1);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= '0;
         fc_ff <= '0;
         strobe_ff <= 1'b0;
         delay_ff <= RST_REUSE_DELAY;
         early_ff <= RST_EARLY_WINDOW;
         prot_ff <= RST_PROTECTED;
         del_en_ff <= RST_DELETE_EN;
         warn_en_ff <= RST_LOW_WARN_EN;
         thr_ff <= RST_LOW_THRESHOLD;
      end else begin
         hw_ff <= hw_in;
         fc_ff <= fc_in;
         strobe_ff <= strobe_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_REUSE_DELAY: delay_ff <= csr_wdata;
               CSR_EARLY_WINDOW: early_ff <= csr_wdata;
               CSR_PROTECTED: prot_ff <= csr_wdata[7:0];
               CSR_DELETE_EN: del_en_ff <= csr_wdata[0];
               CSR_LOW_WARN_EN: warn_en_ff <= csr_wdata[0];
               CSR_LOW_THRESHOLD: thr_ff <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         func_ff <= req_func;
         idx_ff <= req_slot_index;
         now_ff <= req_now_ms;
      end
      ptr_ff <= ptr_in;
      bits_ff <= bits_in;
      word_ff <= word_in;
      st_ff <= st_in;
      slot_ff <= slot_in;
      ser_ff <= ser_in;
      del_ff <= del_in;
      low_ff <= low_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = st_ff;
   assign rsp_granted_slot = slot_ff;
   assign rsp_slot_serial = ser_ff;
   assign rsp_explicit_delete = del_ff;
   assign rsp_low_space = low_ff;
   assign rsp_used_span = COUNT_W'(hw_ff);
   assign rsp_free_total = COUNT_W'(fc_ff);

`ifndef SYNTHESIS
   a_free_within_span: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= hw_ff) else $error("free count above high-water mark");
   a_span_bounded: assert property (@(posedge clock) disable iff (reset)
      EXT_W'(hw_ff) <= EXT_W'(SLOTS)) else $error("high-water mark beyond table");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff) else $error("back-to-back result strobes");
`endif

endmodule

>>> rtl/deferred_reuse_slot_allocator.sv
`timescale 1ns / 1ps
// Slot allocator with deferred reuse. A request is taken when start is high and
// busy is low; its single result appears in the cycle after the last work cycle
// on the rsp_ ports for one cycle with rsp_strobe, and cannot be held off. Forced
// allocate and free pass the decode and index evaluation states before the
// strobe, an index at or above the high-water mark only the decode state.
// Allocate and immediate reuse pass the decode state, then walk the free map one
// 32-slot word at a time: each word up to the high-water mark passes the read,
// load and pick states, each freed slot whose age is tested (allocate) the pick
// and evaluate states, each free slot whose time is zeroed (reuse) the pick
// state; the walk ends in the read state, a fresh slot the fresh and fresh write
// states. The walk over the free-map memory sets the rate. Slot data is only
// used below the high-water mark, which reset clears, so no clearing pass runs.
module deferred_reuse_slot_allocator
   import drsa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [FUNC_W-1:0] req_func,
   input logic [INDEX_W-1:0] req_slot_index,
   input logic [TIME_W-1:0] req_now_ms,
   input logic csr_write_en,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata,
   output logic rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0] rsp_granted_slot,
   output logic [SERIAL_W-1:0] rsp_slot_serial,
   output logic rsp_explicit_delete,
   output logic rsp_low_space,
   output logic [COUNT_W-1:0] rsp_used_span,
   output logic [COUNT_W-1:0] rsp_free_total
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   drsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // slot tables, counters and result registers
   drsa_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_func),
      .req_slot_index      (req_slot_index),
      .req_now_ms          (req_now_ms),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_slot_serial     (rsp_slot_serial),
      .rsp_explicit_delete (rsp_explicit_delete),
      .rsp_low_space       (rsp_low_space),
      .rsp_used_span       (rsp_used_span),
      .rsp_free_total      (rsp_free_total)
   );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import drsa_pkg::*;

   // one result transaction as the block reports it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0] slot;
      logic [SERIAL_W-1:0] serial;
      logic del;
      logic low;
      logic [COUNT_W-1:0] span;
      logic [COUNT_W-1:0] total;
   } slot_result_t;

   localparam int TABLE_SLOTS = SLOTS_DEFAULT;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FUNC_W-1:0] req_func = FUNC_ALLOC;
   logic [INDEX_W-1:0] req_slot_index = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0] rsp_granted_slot;
   logic [SERIAL_W-1:0] rsp_slot_serial;
   logic rsp_explicit_delete;
   logic rsp_low_space;
   logic [COUNT_W-1:0] rsp_used_span;
   logic [COUNT_W-1:0] rsp_free_total;

   deferred_reuse_slot_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_slot_index(req_slot_index), .req_now_ms(req_now_ms),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_granted_slot(rsp_granted_slot), .rsp_slot_serial(rsp_slot_serial),
      .rsp_explicit_delete(rsp_explicit_delete), .rsp_low_space(rsp_low_space),
      .rsp_used_span(rsp_used_span), .rsp_free_total(rsp_free_total)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the slot table and its registers
   bit shadow_free [TABLE_SLOTS];
   logic [31:0] shadow_freed_at [TABLE_SLOTS];
   logic [15:0] shadow_serial [TABLE_SLOTS];
   int shadow_hw;
   int shadow_free_cnt;
   logic [31:0] cfg_delay;
   logic [31:0] cfg_early;
   int cfg_protected;
   bit cfg_del_en;
   bit cfg_warn_en;
   int cfg_threshold;

   slot_result_t pending_results[$];
   int errors = 0;
   int sent_txns = 0;
   int checked_txns = 0;
   int reuse_hits = 0;
   int exhausted_hits = 0;
   bit no_idle = 1'b0;
   logic [31:0] wall_ms = 32'd0;

   function automatic slot_result_t pack_result(int st, int slot, logic [15:0] ser,
                                                bit del, bit low);
      slot_result_t r;
      r.status = st[STATUS_W-1:0];
      r.slot = slot[INDEX_W-1:0];
      r.serial = ser;
      r.del = del;
      r.low = low;
      r.span = shadow_hw[COUNT_W-1:0];
      r.total = shadow_free_cnt[COUNT_W-1:0];
      return r;
   endfunction

   // claim a slot out of the free list
   function automatic void take_slot(int i);
      shadow_free[i] = 1'b0;
      if (shadow_free_cnt > 0) shadow_free_cnt--;
      shadow_serial[i] = SERIAL_UNASSIGNED;
   endfunction

   // expected result of one request, updating the table copy
   function automatic slot_result_t allocate_outcome(logic [FUNC_W-1:0] fn,
                                                     logic [INDEX_W-1:0] idx,
                                                     logic [31:0] now);
      int i;
      int remaining;
      bit del;
      logic [31:0] fa;
      i = int'(idx);
      case (fn)
         FUNC_ALLOC: begin
            for (int k = 0; k < shadow_hw; k++) begin
               if (!shadow_free[k]) continue;
               fa = shadow_freed_at[k];
               if (fa < cfg_early || (now >= fa && now - fa >= cfg_delay)) begin
                  del = (fa == 0) && cfg_del_en;
                  take_slot(k);
                  reuse_hits++;
                  return pack_result(ST_OK, k, shadow_serial[k], del, 1'b0);
               end
            end
            if (shadow_hw >= TABLE_SLOTS) begin
               exhausted_hits++;
               return pack_result(ST_EXHAUSTED, 0, '0, 1'b0, 1'b0);
            end
            i = shadow_hw;
            shadow_hw++;
            shadow_free[i] = 1'b0;
            shadow_serial[i] = SERIAL_UNASSIGNED;
            remaining = TABLE_SLOTS - shadow_hw;
            return pack_result(ST_OK, i, shadow_serial[i], 1'b0,
                               cfg_warn_en && remaining <= cfg_threshold);
         end
         FUNC_FORCE: begin
            if (i >= shadow_hw) return pack_result(ST_BAD_INDEX, i, '0, 1'b0, 1'b0);
            if (!shadow_free[i])
               return pack_result(ST_BAD_INDEX, i, shadow_serial[i], 1'b0, 1'b0);
            take_slot(i);
            return pack_result(ST_OK, i, shadow_serial[i], 1'b0, 1'b0);
         end
         FUNC_FREE: begin
            if (i >= shadow_hw) return pack_result(ST_BAD_INDEX, i, '0, 1'b0, 1'b0);
            if (shadow_free[i] || (i >= 1 && i <= cfg_protected))
               return pack_result(ST_IGNORED, i, shadow_serial[i], 1'b0, 1'b0);
            shadow_free[i] = 1'b1;
            shadow_freed_at[i] = now;
            shadow_free_cnt++;
            shadow_serial[i] = shadow_serial[i] + 16'd1;
            return pack_result(ST_OK, i, shadow_serial[i], 1'b0, 1'b0);
         end
         default: begin
            for (int k = cfg_protected + 1; k < shadow_hw; k++)
               if (shadow_free[k]) shadow_freed_at[k] = '0;
            return pack_result(ST_OK, 0, '0, 1'b0, 1'b0);
         end
      endcase
   endfunction

   // mismatch report
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(negedge clock) begin
      slot_result_t want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transaction", rsp_granted_slot, -1);
         end else begin
            want = pending_results.pop_front();
            checked_txns++;
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_granted_slot !== want.slot)
               report_mismatch("granted_slot", rsp_granted_slot, want.slot);
            if (rsp_slot_serial !== want.serial)
               report_mismatch("slot_serial", rsp_slot_serial, want.serial);
            if (rsp_explicit_delete !== want.del)
               report_mismatch("explicit_delete", rsp_explicit_delete, want.del);
            if (rsp_low_space !== want.low)
               report_mismatch("low_space", rsp_low_space, want.low);
            if (rsp_used_span !== want.span)
               report_mismatch("used_span", rsp_used_span, want.span);
            if (rsp_free_total !== want.total)
               report_mismatch("free_total", rsp_free_total, want.total);
         end
      end
   end

   // send one request transaction; called and returns at a rising edge
   task automatic send_request(logic [FUNC_W-1:0] fn, logic [INDEX_W-1:0] idx,
                               logic [31:0] now);
      start <= 1'b1;
      req_func <= fn;
      req_slot_index <= idx;
      req_now_ms <= now;
      do @(negedge clock); while (busy !== 1'b0);
      @(posedge clock);
      pending_results.push_back(allocate_outcome(fn, idx, now));
      sent_txns++;
      if (!no_idle && $urandom_range(99) < 21) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // wait until every expected result has come or the guard runs out, then let the block settle
   task automatic wait_drained();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   // register write, only while idle; the caller drops the write enable
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, int value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_REUSE_DELAY: cfg_delay = value & 32'hFFFF;
         CSR_EARLY_WINDOW: cfg_early = value & 32'hFFFF;
         CSR_PROTECTED: cfg_protected = value & 8'hFF;
         CSR_DELETE_EN: cfg_del_en = value[0];
         CSR_LOW_WARN_EN: cfg_warn_en = value[0];
         CSR_LOW_THRESHOLD: cfg_threshold = value & 12'hFFF;
         default: ;
      endcase
   endtask

   task automatic set_config(int delay, int early, int prot, int del_en, int warn_en,
                             int thresh);
      wait_drained();
      write_csr(CSR_REUSE_DELAY, delay);
      write_csr(CSR_EARLY_WINDOW, early);
      write_csr(CSR_PROTECTED, prot);
      write_csr(CSR_DELETE_EN, del_en);
      write_csr(CSR_LOW_WARN_EN, warn_en);
      write_csr(CSR_LOW_THRESHOLD, thresh);
      csr_write_en <= 1'b0;
   endtask

   // directed corners: fresh and reused grants, bad and ignored cases, time extremes
   task automatic test_directed();
      send_request(FUNC_ALLOC, 11'd0, 32'd0);
      send_request(FUNC_ALLOC, 11'd0, 32'd10);
      send_request(FUNC_ALLOC, 11'd0, 32'd20);
      send_request(FUNC_ALLOC, 11'd0, 32'd30);
      // freed late: too young, then old enough
      send_request(FUNC_FREE, 11'd1, 32'd5000);
      send_request(FUNC_ALLOC, 11'd0, 32'd5500);
      send_request(FUNC_ALLOC, 11'd0, 32'd6000);
      // freed inside the early window
      send_request(FUNC_FREE, 11'd2, 32'd100);
      send_request(FUNC_ALLOC, 11'd0, 32'd150);
      // duplicate free, bad indexes, busy forced slot
      send_request(FUNC_FREE, 11'd3, 32'hFFFF_FFFF);
      send_request(FUNC_FREE, 11'd3, 32'd7000);
      send_request(FUNC_FREE, 11'd2047, 32'd7000);
      send_request(FUNC_FORCE, 11'd2047, 32'd7000);
      send_request(FUNC_FORCE, 11'd0, 32'd7000);
      // clock behind the free time
      send_request(FUNC_ALLOC, 11'd0, 32'd8000);
      // immediate reuse then a zero free time asks for delete
      send_request(FUNC_REUSE, 11'h555, 32'hAAAA_AAAA);
      send_request(FUNC_ALLOC, 11'h2AA, 32'h5555_5555);
      send_request(FUNC_FREE, 11'd0, 32'd9000);
      send_request(FUNC_FORCE, 11'd0, 32'd9000);
      // protected player slot
      set_config(0, 0, 255, 0, 1, 2048);
      send_request(FUNC_FREE, 11'd1, 32'd9100);
      send_request(FUNC_FREE, 11'd0, 32'd9100);
      send_request(FUNC_ALLOC, 11'd0, 32'd9100);
      send_request(FUNC_ALLOC, 11'd0, 32'd9100);
   endtask

   // random mix of well-formed traffic around the high-water mark
   task automatic random_burst(int count);
      logic [FUNC_W-1:0] fn;
      logic [INDEX_W-1:0] idx;
      logic [31:0] now;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 35) fn = FUNC_ALLOC;
         else if (pick < 50) fn = FUNC_FORCE;
         else if (pick < 92) fn = FUNC_FREE;
         else fn = FUNC_REUSE;
         if ($urandom_range(9) == 0) idx = INDEX_W'($urandom);
         else idx = INDEX_W'($urandom_range(0, shadow_hw + 2 > 2047 ? 2047 : shadow_hw + 2));
         wall_ms = wall_ms + $urandom_range(0, 600);
         pick = $urandom_range(19);
         if (pick == 0) now = $urandom;
         else if (pick == 1) now = $urandom_range(0, 3000);
         else now = wall_ms;
         send_request(fn, idx, now);
      end
   endtask

   task automatic test_random_phases();
      int delay;
      int early;
      int prot;
      for (int p = 0; p < 5; p++) begin
         case (p % 3)
            0: delay = 0;
            1: delay = 65535;
            default: delay = $urandom_range(0, 3000);
         endcase
         early = (p == 1) ? 65535 : (p == 3 ? 0 : $urandom_range(0, 4000));
         prot = (p == 4) ? 255 : $urandom_range(0, 6);
         set_config(delay, early, prot, $urandom_range(1), $urandom_range(1),
                    $urandom_range(0, 2048));
         no_idle = (p == 2);
         random_burst(140);
      end
      no_idle = 1'b0;
   endtask

   // sender holds off mid-stream until everything is back
   task automatic test_pause();
      random_burst(40);
      wait_drained();
      random_burst(40);
   endtask

   // fill the table to exhaustion with the low-space warning on
   task automatic test_fill();
      set_config(65535, 0, 0, 1, 1, $urandom_range(0, 64));
      while (shadow_hw < TABLE_SLOTS)
         send_request(FUNC_ALLOC, INDEX_W'($urandom), $urandom);
      send_request(FUNC_ALLOC, 11'd0, 32'd0);
      send_request(FUNC_FREE, 11'd2047, 32'd5);
      send_request(FUNC_FORCE, 11'd2047, 32'd5);
      send_request(FUNC_FREE, 11'd2047, 32'd5);
      set_config(1000, 2000, 0, 1, 0, 8);
      random_burst(60);
   endtask

   initial begin
      cfg_delay = 32'(RST_REUSE_DELAY);
      cfg_early = 32'(RST_EARLY_WINDOW);
      cfg_protected = int'(RST_PROTECTED);
      cfg_del_en = RST_DELETE_EN;
      cfg_warn_en = RST_LOW_WARN_EN;
      cfg_threshold = int'(RST_LOW_THRESHOLD);
      shadow_hw = 0;
      shadow_free_cnt = 0;
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         shadow_free[k] = 1'b0;
         shadow_freed_at[k] = '0;
         shadow_serial[k] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      test_pause();
      test_fill();
      wait_drained();
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", pending_results.size(), 0);
      $display("covered %0d requests, %0d results checked", sent_txns, checked_txns);
      $display("%0d reused grants, %0d exhausted allocations", reuse_hits, exhausted_hits);
      if (errors == 0) $display("** deferred_reuse_slot_allocator: PASSED **");
      else $display("** deferred_reuse_slot_allocator: FAILED **");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000_000;
      $display("timeout");
      $display("** deferred_reuse_slot_allocator: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
rtl/drsa_pkg.sv
rtl/drsa_ram.sv
rtl/drsa_ctrl.sv
rtl/drsa_datapath.sv
rtl/deferred_reuse_slot_allocator.sv
dv/tb_top.sv
